@@ rtl/zzr_pkg.sv @@
// shared types and constants of the zigzag row reorder unit
`timescale 1ns / 1ps

package zzr_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROWS_W = 7;
  localparam int unsigned STEP_W = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              is_last;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_out;
    logic              truncated;
  } out_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic store;
    logic begin_run;
    logic issue;
    logic next_row;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_range;
    logic final_item;
  } status_t;

endpackage

@@ rtl/zzr_ctrl.sv @@
// controller state machine: load / emit sequencing
`timescale 1ns / 1ps

module zzr_ctrl
  import zzr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    is_last_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && is_last_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.in_range && status_i.final_item) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.store     = start;
        cmd_o.begin_run = start && is_last_i;
      end
      ST_RUN: begin
        busy           = 1'b1;
        cmd_o.issue    = status_i.in_range;
        cmd_o.next_row = !status_i.in_range;
        cmd_o.finish   = status_i.in_range && status_i.final_item;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/zzr_datapath.sv @@
// datapath: byte buffer, fill count, zigzag index walker, result register
`timescale 1ns / 1ps

module zzr_datapath
  import zzr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ROWS_W-1:0] cfg_wdata_i,
  input  in_t               in_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              result_valid_o,
  output out_t              res_o
);

  localparam int unsigned AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(BUF_DEPTH + 2 * (1 << STEP_W));

  typedef struct packed {
    logic [STEP_W-1:0] s0;
    logic [STEP_W-1:0] s1;
  } steps_t;

  // the two alternating steps of one row
  function automatic steps_t row_steps(input logic [ROWS_W-1:0] rows,
                                       input logic [ROWS_W-1:0] row);
    steps_t            st;
    logic [STEP_W-1:0] stride;
    begin
      stride = {rows - 1'b1, 1'b0};
      st.s0  = stride - {row, 1'b0};
      if (st.s0 == '0) st.s0 = stride;
      st.s1  = stride - st.s0;
      if (st.s1 == '0) st.s1 = stride;
      if (rows < ROWS_W'(2)) begin
        st.s0 = STEP_W'(1);
        st.s1 = STEP_W'(1);
      end
      row_steps = st;
    end
  endfunction

  logic [CHAR_W-1:0] mem [BUF_DEPTH];

  logic [ROWS_W-1:0] rows_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [ROWS_W-1:0] row_q, row_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              sel_q, sel_d;
  logic [CNT_W-1:0]  k_q, k_d;
  steps_t            steps_q, steps_d;
  logic              valid_q;
  logic [CHAR_W-1:0] rd_data_q;
  logic              last_q;
  logic              trunc_q;
  logic              full;

  assign full = (fill_q == CNT_W'(BUF_DEPTH));

  assign status_o.in_range   = (idx_q < IDX_W'(fill_q));
  assign status_o.final_item = ((k_q + 1'b1) == fill_q);

  always_comb begin
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    row_d   = row_q;
    idx_d   = idx_q;
    sel_d   = sel_q;
    k_d     = k_q;
    steps_d = steps_q;
    if (cmd_i.store) begin
      if (full) ovf_d = 1'b1;
      else fill_d = fill_q + 1'b1;
    end
    if (cmd_i.begin_run) begin
      row_d   = '0;
      idx_d   = '0;
      sel_d   = 1'b0;
      k_d     = '0;
      steps_d = row_steps(rows_q, '0);
    end
    if (cmd_i.issue) begin
      idx_d = idx_q + IDX_W'(sel_q ? steps_q.s1 : steps_q.s0);
      sel_d = !sel_q;
      k_d   = k_q + 1'b1;
    end
    if (cmd_i.next_row) begin
      row_d   = row_q + 1'b1;
      idx_d   = IDX_W'(row_d);
      sel_d   = 1'b0;
      steps_d = row_steps(rows_q, row_d);
    end
    if (cmd_i.finish) begin
      fill_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_W'(1);
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      row_q   <= '0;
      idx_q   <= '0;
      sel_q   <= 1'b0;
      k_q     <= '0;
      steps_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rows_q <= cfg_wdata_i;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      row_q   <= row_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
      k_q     <= k_d;
      steps_q <= steps_d;
      valid_q <= cmd_i.issue;
    end
  end

  // buffer write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) mem[fill_q[AW-1:0]] <= in_i.char_in;
    if (cmd_i.issue) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
      last_q    <= status_o.final_item;
      trunc_q   <= ovf_q;
    end
  end

  assign result_valid_o = valid_q;
  assign res_o.char_out  = rd_data_q;
  assign res_o.last_out  = last_q;
  assign res_o.truncated = trunc_q;

endmodule

@@ rtl/zigzag_row_reorder_unit.sv @@
// top level of the zigzag (rail fence) row reorder unit
`timescale 1ns / 1ps
//
// channel  | ports                          | handshake
// ---------+--------------------------------+---------------------------------
// input    | item_i (char_in, is_last)      | accepted when start && !busy
// result   | res_o (char_out, last_out,     | one cycle, marked by
//          |        truncated)              | result_valid_o, no back-pressure
// config   | cfg_wdata_i (num_rows)         | written when cfg_we_i is high
//
// a byte without is_last is only written into the buffer
// an item with is_last starts a run: one buffer read per emitted byte, plus
// an idle step at the end of every row before the one holding the final byte,
// where the index has run past the string; busy stays high for the whole run,
// and with zero or one row there are no idle steps
// each result appears in the output register in the cycle after its buffer read
// reset clears the fill count, the overflow flag and the controller;
// num_rows returns to one row, buffer contents are not cleared
//
module zigzag_row_reorder_unit
  import zzr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              start,
  output logic              busy,
  input  in_t               item_i,
  // results
  output logic              result_valid_o,
  output out_t              res_o,
  // configuration
  input  logic              cfg_we_i,
  input  logic [ROWS_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  // controller: idle while loading, runs the zigzag walk after the last byte
  zzr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .is_last_i (item_i.is_last),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // datapath: buffer, row and index walker, result register
  zzr_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_i           (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench of the zigzag row reorder unit with its own rail fence predictor
`timescale 1ns / 1ps

module tb_top;
  import zzr_pkg::*;

  localparam int unsigned DEPTH = 64;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               item_i = '0;
  logic              result_valid_o;
  out_t              res_o;
  logic              cfg_we_i = 1'b0;
  logic [ROWS_W-1:0] cfg_wdata_i = '0;

  zigzag_row_reorder_unit #(
    .BUF_DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .res_o         (res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // predictor state: string buffer, fill level, drop flag, row count
  logic [CHAR_W-1:0] char_buf [DEPTH];
  int unsigned       fill_cnt = 0;
  logic              drop_seen = 1'b0;
  logic [ROWS_W-1:0] rows_cfg = 7'd1;

  in_t  char_q [$];      // items waiting to be sent
  out_t fence_out_q [$]; // reordered bytes still to come out
  int   idle_pct = 10;
  int   mismatches = 0;
  out_t want;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

  // store one byte and, on the last one, queue the string in zigzag row order
  task automatic predict_rail_fence(input in_t it);
    int unsigned len, rows, stride, row, idx, sel;
    int unsigned steps [2];
    int unsigned order [$];
    out_t r;
    if (fill_cnt < DEPTH) begin
      char_buf[fill_cnt] = it.char_in;
      fill_cnt++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!it.is_last) return;
    len  = fill_cnt;
    rows = rows_cfg;
    if (rows <= 1) begin
      // zero or one row: the string passes through unchanged
      for (idx = 0; idx < len; idx++) order.push_back(idx);
    end else begin
      stride = 2 * (rows - 1);
      for (row = 0; row < rows; row++) begin
        idx = row;
        sel = 0;
        steps[0] = stride - 2 * row;
        if (steps[0] == 0) steps[0] = stride;
        steps[1] = stride - steps[0];
        if (steps[1] == 0) steps[1] = stride;
        // rows that start past the string contribute nothing
        while (idx < len && order.size() < len) begin
          order.push_back(idx);
          idx += steps[sel];
          sel ^= 1;
        end
      end
    end
    foreach (order[i]) begin
      r.char_out  = char_buf[order[i]];
      r.last_out  = (i == order.size() - 1);
      r.truncated = drop_seen;
      fence_out_q.push_back(r);
    end
    fill_cnt  = 0;
    drop_seen = 1'b0;
  endtask

  // driver: start stays up until busy is low at an edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) predict_rail_fence(item_i);
      if (!start || !busy) begin
        if (char_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start  <= 1'b1;
          item_i <= char_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result must match the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (fence_out_q.size() == 0) begin
        $display("%0t: unexpected result char_out=%h last_out=%b truncated=%b",
                 $time, res_o.char_out, res_o.last_out, res_o.truncated);
        mismatches++;
      end else begin
        want = fence_out_q.pop_front();
        if (res_o.char_out !== want.char_out || res_o.last_out !== want.last_out ||
            res_o.truncated !== want.truncated) begin
          $display("%0t: mismatch expected char_out=%h last_out=%b truncated=%b, got %h %b %b",
                   $time, want.char_out, want.last_out, want.truncated,
                   res_o.char_out, res_o.last_out, res_o.truncated);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_byte(input logic [CHAR_W-1:0] c, input logic l);
    in_t it;
    it.char_in = c;
    it.is_last = l;
    char_q.push_back(it);
  endtask

  // random string, extremes mixed in now and then
  task automatic queue_string(input int unsigned len);
    logic [CHAR_W-1:0] c;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       c = 8'h00;
        1:       c = 8'hFF;
        default: c = CHAR_W'($urandom);
      endcase
      queue_byte(c, i == len - 1);
    end
  endtask

  // wait for everything sent and emitted, then for the empty rows of the last run
  task automatic settle();
    do @(negedge clk_i); while (char_q.size() != 0 || start);
    while (fence_out_q.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (int'(rows_cfg) + 8) @(negedge clk_i);
  endtask

  task automatic set_rows(input logic [ROWS_W-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    rows_cfg     = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [ROWS_W-1:0] row_plan [3][3];
    int unsigned queued, n;

    while (!rst_ni) @(negedge clk_i);

    // directed: reset row count of one, then zero rows, small strides,
    // rows beyond the string length and the largest encodable row count
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    set_rows(7'd0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h01, 1'b1);
    set_rows(7'd2);
    for (int i = 0; i < 5; i++) queue_byte(CHAR_W'(8'h10 + i), i == 4);
    set_rows(7'd3);
    for (int i = 0; i < 7; i++) queue_byte(CHAR_W'(8'h20 + i), i == 6);
    set_rows(7'd64);
    for (int i = 0; i < 3; i++) queue_byte(CHAR_W'(8'hF0 + i), i == 2);
    set_rows(7'd127);
    for (int i = 0; i < 4; i++) queue_byte(CHAR_W'(8'h80 + i), i == 3);

    row_plan[0] = '{7'd2, 7'd4, 7'($urandom_range(1, 64))};
    row_plan[1] = '{7'd1, 7'($urandom_range(2, 8)), 7'($urandom_range(0, 127))};
    row_plan[2] = '{7'd64, 7'd3, 7'($urandom_range(2, 16))};

    // random: sender idles 10%, then 85%, then never
    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < 3; s++) begin
        set_rows(row_plan[ph][s]);
        idle_pct = (ph == 0) ? 10 : (ph == 1) ? 85 : 0;
        // one string overruns the buffer, its last byte is dropped too
        if (ph == 1 && s == 1) queue_string(DEPTH + 2);
        queued = 0;
        while (queued < 12) begin
          n = $urandom_range(1, 12);
          queue_string(n);
          queued += n;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
